// ----- hw/rtl/nbon_pkg.sv -----
// ----------------------------------------------------------------------------
// nbon_pkg
// shared types and constants for the normal basis orbit naming block
// ----------------------------------------------------------------------------
package nbon_pkg;

    localparam int FIELD_DEGREE_DEF = 131;
    localparam int RING_SIZE_DEF    = 263;

    // fixed layout of the coordinate and name words
    localparam int LANE_W    = 64;
    localparam int HIGH_W    = 3;
    localparam int WORD_BITS = 2 * LANE_W + HIGH_W;

    // width of the generator index register
    localparam int GEN_W = 8;

    typedef struct packed {
        logic [HIGH_W-1:0] coord_high;
        logic [LANE_W-1:0] coord_mid;
        logic [LANE_W-1:0] coord_low;
    } coord_word_t;

    typedef struct packed {
        logic [HIGH_W-1:0] name_high;
        logic [LANE_W-1:0] name_mid;
        logic [LANE_W-1:0] name_low;
    } name_word_t;

    // select width for one source coordinate, the source vector being at least a word wide
    function automatic int idx_width(input int m);
        int ew;
        ew = (m > WORD_BITS) ? m : WORD_BITS;
        return $clog2(ew);
    endfunction

endpackage

// ----- hw/rtl/normal_basis_orbit_name.sv -----
// ----------------------------------------------------------------------------
// normal_basis_orbit_name
// least cyclic rotation of a field element re-read into a chosen normal basis
// ----------------------------------------------------------------------------
// usage
//   input word: raise start with coord; it is taken at a rising edge where
//   busy is low. a new word may be taken every cycle.
//   result word: done is high for exactly one cycle with name holding the
//   least rotation; the receiver cannot stall, so the pipeline never holds.
//   pipeline: one input register, one permute stage and FIELD_DEGREE - 1
//   rotate and compare stages, one FIELD_DEGREE-bit compare each.
//   throughput: one word per cycle while busy is low.
//   config: cfg_we with cfg_wdata loads the generator index; the user
//   writes it only while no word is in flight, which the block does not
//   enforce. each write, and reset, starts a table rebuild (reduce the
//   index, then one table entry a cycle); busy stays high over it and
//   start is ignored.
//   reset: rst_n clears all valid bits, loads generator index 1 and runs
//   the table rebuild.
// ----------------------------------------------------------------------------
module normal_basis_orbit_name #(
    parameter int FIELD_DEGREE = nbon_pkg::FIELD_DEGREE_DEF,
    parameter int RING_SIZE    = nbon_pkg::RING_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  nbon_pkg::coord_word_t      coord,
    output logic                       done,
    output nbon_pkg::name_word_t       name,
    input  logic                       cfg_we,
    input  logic [nbon_pkg::GEN_W-1:0] cfg_wdata
);
    import nbon_pkg::*;

    localparam int IDX_W = idx_width(FIELD_DEGREE);
    localparam int EW    = (FIELD_DEGREE > WORD_BITS) ? FIELD_DEGREE : WORD_BITS;

    logic                               accept;
    logic [FIELD_DEGREE-1:0][IDX_W-1:0] map_idx;
    logic [FIELD_DEGREE-1:0]            map_hit;
    logic [FIELD_DEGREE-1:0]            perm_word;

    // stage 0 is the permuted word; stage r has seen rotations up to r
    logic [FIELD_DEGREE-1:0]                    stg_valid;
    logic [FIELD_DEGREE-1:0][FIELD_DEGREE-1:0]  stg_cur;
    logic [FIELD_DEGREE-1:0][FIELD_DEGREE-1:0]  stg_best;

    logic [EW-1:0] best_ext;

    // a word goes in only when the select table is complete
    assign accept = start & ~busy;

    nbon_basis_map #(
        .FIELD_DEGREE (FIELD_DEGREE),
        .RING_SIZE    (RING_SIZE),
        .IDX_W        (IDX_W)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .map_idx   (map_idx),
        .map_hit   (map_hit)
    );

    nbon_permute #(
        .FIELD_DEGREE (FIELD_DEGREE),
        .IDX_W        (IDX_W)
    ) u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .coord   (coord),
        .map_idx (map_idx),
        .map_hit (map_hit),
        .valid   (stg_valid[0]),
        .word    (perm_word)
    );

    // the unrotated word is the first candidate
    assign stg_cur[0]  = perm_word;
    assign stg_best[0] = perm_word;

    // rotate and compare chain, one rotation per stage
    for (genvar r = 1; r < FIELD_DEGREE; r++)
    begin : g_rot
        nbon_rot_stage #(
            .FIELD_DEGREE (FIELD_DEGREE)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stg_valid[r-1]),
            .cur_in    (stg_cur[r-1]),
            .best_in   (stg_best[r-1]),
            .valid_out (stg_valid[r]),
            .cur_out   (stg_cur[r]),
            .best_out  (stg_best[r])
        );
    end

    // the last stage registers are the result word
    always_comb
    begin
        best_ext       = EW'(stg_best[FIELD_DEGREE-1]);
        name.name_low  = best_ext[LANE_W-1:0];
        name.name_mid  = best_ext[2*LANE_W-1:LANE_W];
        name.name_high = best_ext[WORD_BITS-1:2*LANE_W];
    end

    assign done = stg_valid[FIELD_DEGREE-1];

endmodule

// ----- hw/rtl/nbon_basis_map.sv -----
// ----------------------------------------------------------------------------
// nbon_basis_map
// generator register and the sequencer that rebuilds the coordinate select table
// ----------------------------------------------------------------------------
module nbon_basis_map #(
    parameter int FIELD_DEGREE = nbon_pkg::FIELD_DEGREE_DEF,
    parameter int RING_SIZE    = nbon_pkg::RING_SIZE_DEF,
    parameter int IDX_W        = nbon_pkg::idx_width(nbon_pkg::FIELD_DEGREE_DEF)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nbon_pkg::GEN_W-1:0]           cfg_wdata,
    output logic                                 busy,
    output logic [FIELD_DEGREE-1:0][IDX_W-1:0]   map_idx,
    output logic [FIELD_DEGREE-1:0]              map_hit
);
    import nbon_pkg::*;

    localparam int RW    = $clog2(RING_SIZE);
    localparam int SWEEP = GEN_W + FIELD_DEGREE;
    localparam int CNT_W = $clog2(SWEEP);
    localparam int KW    = (FIELD_DEGREE > 1) ? $clog2(FIELD_DEGREE) : 1;
    localparam int BW    = $clog2(GEN_W);

    logic [GEN_W-1:0] gen_reg;
    logic             sweep_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    e_reg;

    logic [CNT_W-1:0] cnt_next;
    logic [RW-1:0]    e_next;
    logic             in_bits;
    logic             bit_in;
    logic [RW:0]      dbl;
    logic [CNT_W-1:0] k_full;
    logic [KW-1:0]    k;
    logic [RW-1:0]    f;
    logic [RW-1:0]    f_m1;
    logic             f_hit;
    logic             wr_en;

    logic [FIELD_DEGREE-1:0][IDX_W-1:0] map_idx_reg;
    logic [FIELD_DEGREE-1:0]            map_hit_reg;

    always_comb
    begin
        // first the generator bits, msb first, to reduce it mod ring size
        in_bits = (cnt_reg < CNT_W'(GEN_W));
        bit_in  = in_bits & gen_reg[BW'(GEN_W - 1) - cnt_reg[BW-1:0]];
        dbl     = {e_reg, bit_in};
        if (dbl >= (RW+1)'(RING_SIZE))
        begin
            dbl = dbl - (RW+1)'(RING_SIZE);
        end
        e_next   = dbl[RW-1:0];
        cnt_next = cnt_reg + CNT_W'(1);

        // fold the ring position into a one-based basis element
        if (e_reg <= RW'(FIELD_DEGREE))
        begin
            f = e_reg;
        end
        else
        begin
            f = RW'(RING_SIZE) - e_reg;
        end
        f_hit  = (f != '0) && (f <= RW'(FIELD_DEGREE));
        f_m1   = f - RW'(1);
        k_full = cnt_reg - CNT_W'(GEN_W);
        k      = k_full[KW-1:0];
        wr_en  = sweep_reg & ~in_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg   <= GEN_W'(1);
            sweep_reg <= 1'b1;
            cnt_reg   <= '0;
            e_reg     <= '0;
        end
        else if (cfg_we)
        begin
            gen_reg   <= cfg_wdata;
            sweep_reg <= 1'b1;
            cnt_reg   <= '0;
            e_reg     <= '0;
        end
        else if (sweep_reg)
        begin
            e_reg   <= e_next;
            cnt_reg <= cnt_next;
            if (cnt_reg == CNT_W'(SWEEP - 1))
            begin
                sweep_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_idx_reg[k] <= IDX_W'(f_m1);
            map_hit_reg[k] <= f_hit;
        end
    end

    assign busy    = sweep_reg | cfg_we;
    assign map_idx = map_idx_reg;
    assign map_hit = map_hit_reg;

endmodule

// ----- hw/rtl/nbon_permute.sv -----
// ----------------------------------------------------------------------------
// nbon_permute
// input register and the coordinate re-read into the target normal basis
// ----------------------------------------------------------------------------
module nbon_permute #(
    parameter int FIELD_DEGREE = nbon_pkg::FIELD_DEGREE_DEF,
    parameter int IDX_W        = nbon_pkg::idx_width(nbon_pkg::FIELD_DEGREE_DEF)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  nbon_pkg::coord_word_t                coord,
    input  logic [FIELD_DEGREE-1:0][IDX_W-1:0]   map_idx,
    input  logic [FIELD_DEGREE-1:0]              map_hit,
    output logic                                 valid,
    output logic [FIELD_DEGREE-1:0]              word
);
    import nbon_pkg::*;

    localparam int EW = (FIELD_DEGREE > WORD_BITS) ? FIELD_DEGREE : WORD_BITS;

    coord_word_t             coord_reg;
    logic                    in_valid_reg;
    logic [FIELD_DEGREE-1:0] perm_reg;
    logic                    perm_valid_reg;

    logic [EW-1:0]           src_ext;
    logic [FIELD_DEGREE-1:0] perm_next;

    always_comb
    begin
        src_ext = EW'(coord_reg);
        for (int k = 0; k < FIELD_DEGREE; k++)
        begin
            perm_next[k] = map_hit[k] & src_ext[map_idx[k]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            perm_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= accept;
            perm_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg <= coord;
        end
        perm_reg <= perm_next;
    end

    assign valid = perm_valid_reg;
    assign word  = perm_reg;

endmodule

// ----- hw/rtl/nbon_rot_stage.sv -----
// ----------------------------------------------------------------------------
// nbon_rot_stage
// one rotation step: rotate left by one and keep the smaller of rotation and best
// ----------------------------------------------------------------------------
module nbon_rot_stage #(
    parameter int FIELD_DEGREE = nbon_pkg::FIELD_DEGREE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [FIELD_DEGREE-1:0] cur_in,
    input  logic [FIELD_DEGREE-1:0] best_in,
    output logic                    valid_out,
    output logic [FIELD_DEGREE-1:0] cur_out,
    output logic [FIELD_DEGREE-1:0] best_out
);
    logic                    valid_reg;
    logic [FIELD_DEGREE-1:0] cur_reg;
    logic [FIELD_DEGREE-1:0] best_reg;

    logic [FIELD_DEGREE-1:0] cur_next;
    logic [FIELD_DEGREE-1:0] best_next;

    always_comb
    begin
        cur_next  = {cur_in[FIELD_DEGREE-2:0], cur_in[FIELD_DEGREE-1]};
        best_next = (cur_next < best_in) ? cur_next : best_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        best_reg <= best_next;
    end

    assign valid_out = valid_reg;
    assign cur_out   = cur_reg;
    assign best_out  = best_reg;

endmodule

// ----- hw/rtl/nbon_checker.sv -----
// ----------------------------------------------------------------------------
// nbon_checker
// port level checks of latency and table rebuild timing
// ----------------------------------------------------------------------------
module nbon_checker #(
    parameter int FIELD_DEGREE = nbon_pkg::FIELD_DEGREE_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_we
);
    import nbon_pkg::*;

    localparam int LAT   = FIELD_DEGREE + 1;
    localparam int SWEEP = GEN_W + FIELD_DEGREE;

    // every accepted word gives a result a fixed latency later
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted word");

    // no result without an accepted word at the matching cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching input word");

    // a generator write holds the input off until the table is rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> ##SWEEP busy)
        else $error("busy dropped before table rebuild finished");

endmodule

bind normal_basis_orbit_name nbon_checker #(
    .FIELD_DEGREE (FIELD_DEGREE)
) u_nbon_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cfg_we (cfg_we)
);

// ----- dv/normal_basis_orbit_name_test.sv -----
// ----------------------------------------------------------------------------
// normal_basis_orbit_name_test
// self-checking bench for the normal basis orbit naming block
// ----------------------------------------------------------------------------
// a queue of planned words and generator writes is built at time zero; a
// clocked driver feeds it to the block with random idle bursts and a clocked
// monitor compares every name word, field by field, with the oldest predicted
// name. generator writes only go out once the pipeline has drained.
// ----------------------------------------------------------------------------
module normal_basis_orbit_name_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nbon_pkg::*;

    localparam int M        = FIELD_DEGREE_DEF;
    localparam int RING     = RING_SIZE_DEF;
    // accepting edge to done, plus margin for the final settle
    localparam int LATENCY  = M + 1;
    localparam int SETTLE   = LATENCY + 20;
    localparam int RAND_PER_PHASE = 120;

    // one planned step: either a coordinate word or a generator write
    typedef struct {
        bit                is_write;
        logic [GEN_W-1:0]  gen;
        coord_word_t       coord;
        int unsigned       gap;
    } word_plan_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    coord_word_t       coord = '0;
    logic              done;
    name_word_t        name;
    logic              cfg_we = 1'b0;
    logic [GEN_W-1:0]  cfg_wdata = '0;

    word_plan_t        pending_words[$];
    name_word_t        expected_names[$];

    // the bench's own copy of the generator index register
    logic [GEN_W-1:0]  cur_generator = 8'd1;

    int unsigned       words_sent;
    int unsigned       names_checked;
    int unsigned       generator_writes;
    int unsigned       mismatch_count;

    normal_basis_orbit_name u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .coord     (coord),
        .done      (done),
        .name      (name),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // single reset at the start of the run, released on a rising edge
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // generous hard limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout waiting for the block to finish");
        $display("normal_basis_orbit_name_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // re-reads the coordinates into the basis generated by element gen, then
    // keeps the least of all cyclic rotations
    // ------------------------------------------------------------------------
    function automatic name_word_t least_rotation_name(input coord_word_t c,
                                                       input logic [GEN_W-1:0] gen);
        logic [M-1:0] src;
        logic [M-1:0] perm;
        logic [M-1:0] cur;
        logic [M-1:0] best;
        int unsigned  pow2;
        int unsigned  t;
        int unsigned  f;
        name_word_t   res;
        src  = c;
        perm = '0;
        pow2 = 1;
        for (int k = 0; k < M; k++)
        begin
            t = (int'(gen) * pow2) % RING;
            // fold the ring index back into 0..M
            f = (t <= M) ? t : RING - t;
            // index zero reads as a clear bit
            if (f >= 1 && f <= M)
                perm[k] = src[f-1];
            pow2 = (2 * pow2) % RING;
        end
        best = perm;
        cur  = perm;
        for (int r = 1; r < M; r++)
        begin
            // rotate toward the top, msb wraps into bit 0
            cur = {cur[M-2:0], cur[M-1]};
            if (cur < best)
                best = cur;
        end
        res = best;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // driver
    // one word is held on coord with start high until busy is low at an edge;
    // a generator write waits for an empty pipeline and a finished rebuild
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic raise;
        logic we_nxt;
        if (!rst_n)
        begin
            start  <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            raise  = start;
            we_nxt = 1'b0;
            // word taken at this edge: predict its name under the current index
            if (start && !busy)
            begin
                expected_names = {expected_names, least_rotation_name(coord, cur_generator)};
                words_sent++;
                raise = 1'b0;
            end
            // nothing new in the cycle right after a write, so the rebuild
            // has raised busy before the next word shows up
            if (!raise && !cfg_we && pending_words.size() > 0)
            begin
                if (pending_words[0].is_write)
                begin
                    // write only into an idle block: no word in flight, no rebuild
                    if (expected_names.size() == 0 && !busy && !start)
                    begin
                        we_nxt        = 1'b1;
                        cfg_wdata     <= pending_words[0].gen;
                        cur_generator = pending_words[0].gen;
                        generator_writes++;
                        void'(pending_words.pop_front());
                    end
                end
                else if (pending_words[0].gap > 0)
                begin
                    // idle burst ahead of this word
                    pending_words[0].gap = pending_words[0].gap - 1;
                end
                else
                begin
                    raise = 1'b1;
                    coord <= pending_words[0].coord;
                    void'(pending_words.pop_front());
                end
            end
            start  <= raise;
            cfg_we <= we_nxt;
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // done lasts one cycle and cannot be held off, so each strobe is one word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        name_word_t want;
        if (rst_n && done)
        begin
            if (expected_names.size() == 0)
            begin
                report_mismatch($sformatf("name word with nothing expected: %h", name));
            end
            else
            begin
                want = expected_names.pop_front();
                names_checked++;
                if (name.name_low !== want.name_low)
                    report_mismatch($sformatf("name_low got %h want %h",
                                              name.name_low, want.name_low));
                if (name.name_mid !== want.name_mid)
                    report_mismatch($sformatf("name_mid got %h want %h",
                                              name.name_mid, want.name_mid));
                if (name.name_high !== want.name_high)
                    report_mismatch($sformatf("name_high got %h want %h",
                                              name.name_high, want.name_high));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus plan
    // ------------------------------------------------------------------------
    task automatic plan_word(input logic [M-1:0] v, input int unsigned idle_pct);
        word_plan_t w;
        w.is_write = 1'b0;
        w.gen      = '0;
        w.coord    = v;
        w.gap      = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 11) : 0;
        pending_words = {pending_words, w};
    endtask

    task automatic plan_write(input logic [GEN_W-1:0] gen);
        word_plan_t w;
        w.is_write = 1'b1;
        w.gen      = gen;
        w.coord    = '0;
        w.gap      = 0;
        pending_words = {pending_words, w};
    endtask

    // half full random words, the other half sparse and dense ones so the least
    // rotation lands on long zero runs and near-ties
    task automatic plan_random(input int unsigned count, input int unsigned idle_pct);
        logic [M-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    v = '0;
                    repeat ($urandom_range(1, 4)) v[$urandom_range(0, M-1)] = 1'b1;
                end
                1:
                begin
                    v = '1;
                    repeat ($urandom_range(1, 4)) v[$urandom_range(0, M-1)] = 1'b0;
                end
                default:
                    v = M'({$urandom, $urandom, $urandom, $urandom, $urandom});
            endcase
            plan_word(v, idle_pct);
        end
    endtask

    initial
    begin
        logic [M-1:0]     v;
        logic [M-1:0]     evens;
        logic [GEN_W-1:0] edge_gens[$];
        int unsigned      idle_pct;

        for (int i = 0; i < M; i++)
            evens[i] = (i % 2 == 0);

        // directed words under the reset index: zero, all ones, each lane
        // alone, lane boundary bits, alternating and crossing patterns
        idle_pct = 25;
        plan_word('0, idle_pct);
        plan_word('1, idle_pct);
        v = '0; v[LANE_W-1:0] = '1;              plan_word(v, idle_pct);
        v = '0; v[2*LANE_W-1:LANE_W] = '1;       plan_word(v, idle_pct);
        v = '0; v[M-1:2*LANE_W] = '1;            plan_word(v, idle_pct);
        for (int b = 0; b < M; b++)
        begin
            if (b == 0 || b == 63 || b == 64 || b == 127 || b == 128 || b == 129 ||
                b == M-1)
            begin
                v = '0; v[b] = 1'b1; plan_word(v, idle_pct);
            end
        end
        plan_word(evens, idle_pct);
        plan_word(~evens, idle_pct);
        v = '0; v[0] = 1'b1; v[M-1] = 1'b1;     plan_word(v, idle_pct);
        v = '0; v[67:60] = '1;                   plan_word(v, idle_pct);
        v = '1; v[0] = 1'b0;                     plan_word(v, idle_pct);
        v = '1; v[M-1] = 1'b0;                   plan_word(v, idle_pct);
        plan_random(RAND_PER_PHASE, idle_pct);

        // index extremes: top of range, zero, top of the register, first
        // value above range, and the reset value written back
        edge_gens = '{8'd131, 8'd0, 8'd255, 8'd132, 8'd1};
        foreach (edge_gens[g])
        begin
            idle_pct = (g % 2 == 0) ? 50 : 0;
            plan_write(edge_gens[g]);
            plan_word('1, idle_pct);
            v = '0; v[0] = 1'b1;   plan_word(v, idle_pct);
            v = '0; v[M-1] = 1'b1; plan_word(v, idle_pct);
            plan_word(evens, idle_pct);
            plan_random(RAND_PER_PHASE, idle_pct);
        end

        // random indexes, one of them above range; the last phase runs
        // without idle cycles
        for (int p = 0; p < 6; p++)
        begin
            idle_pct = (p == 5) ? 0 : $urandom_range(0, 2) * 25;
            plan_write(GEN_W'((p == 2) ? $urandom_range(133, 255) : $urandom_range(2, 130)));
            plan_random(RAND_PER_PHASE, idle_pct);
        end

        // everything out, every name back, then a quiet stretch to catch strays
        while (pending_words.size() != 0 || start || expected_names.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d words over %0d generator index settings",
                 words_sent, generator_writes + 1);
        $display("checked %0d names, %0d mismatches", names_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("normal_basis_orbit_name_test OK");
        else
            $display("normal_basis_orbit_name_test NOT OK");
        $finish;
    end

endmodule
